>>> src/masked_bit_plane_transposer_macros.svh
// Assertion macros for the masked bit-plane transposer.
// No dependencies; included by mbpt_merge, the module that carries assertions.
`ifndef MASKED_BIT_PLANE_TRANSPOSER_MACROS_SVH
`define MASKED_BIT_PLANE_TRANSPOSER_MACROS_SVH
`ifndef ASSERT_OFF
`define MBPT_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("mbpt assertion failed");
`define MBPT_NEVER(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("mbpt forbidden condition");
`else
`define MBPT_ASSERT(lbl, clk, rst_n, prop)
`define MBPT_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

>>> src/mbpt_pkg.sv
// Shared types and constants of the masked bit-plane transposer.
// No dependencies; used by every module of the block.
`default_nettype none
package mbpt_pkg;

	localparam int unsigned SamplesDef    = 1924;
	localparam int unsigned SampleBitsDef = 16;
	localparam int unsigned LanesDef      = 32;
	localparam int unsigned SampleW       = 16;
	localparam int unsigned RankW         = 5;
	localparam int unsigned IdxW          = 11;
	localparam int unsigned StepW         = 4;

	typedef enum logic [1:0] {
		OP_HEADER  = 2'd0,
		OP_DATA    = 2'd1,
		OP_TRAILER = 2'd2
	} op_t;

	typedef enum logic {
		KIND_SAMPLE  = 1'b0,
		KIND_TRAILER = 1'b1
	} kind_t;

	typedef struct packed {
		logic [1:0]  op;
		logic [31:0] word;
	} in_t;

	typedef struct packed {
		logic        kind;
		logic [4:0]  chip_rank;
		logic [10:0] sample_index;
		logic [15:0] sample;
		logic [23:0] trigger_id;
		logic [7:0]  module_id;
		logic [63:0] timestamp;
		logic        last;
	} out_t;

	// per-beat control common to all lanes
	typedef struct packed {
		logic             clr;
		logic             shift;
		logic             grp_end;
		logic [StepW-1:0] pos;
	} lane_ctl_t;

	typedef struct packed {
		logic [23:0] trigger_id;
		logic [7:0]  module_id;
		logic [63:0] timestamp;
	} trailer_t;

endpackage
`default_nettype wire

>>> src/mbpt_lane.sv
// One bit lane: accumulates a sample bit per data beat and hands the
// finished sample to a snapshot register. Depends on mbpt_pkg.
`default_nettype none
module mbpt_lane (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire mbpt_pkg::lane_ctl_t                 ctl,
	input  wire logic                                bit_in,
	output logic        [mbpt_pkg::SampleW-1:0]      snap
);

	logic [mbpt_pkg::SampleW-1:0] acc_q;
	logic [mbpt_pkg::SampleW-1:0] acc_nxt;
	logic [mbpt_pkg::SampleW-1:0] snap_q;

	assign acc_nxt = acc_q | (mbpt_pkg::SampleW'(bit_in) << ctl.pos);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (ctl.clr) begin
			acc_q <= '0;
		end else if (ctl.shift) begin
			acc_q <= ctl.grp_end ? '0 : acc_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.shift && ctl.grp_end) begin
			snap_q <= acc_nxt;
		end
	end

	assign snap = snap_q;

endmodule
`default_nettype wire

>>> src/mbpt_merge.sv
// Merging stage: walks the snapshot of the enabled lanes in rank order,
// slots in the trailer result and holds the output register. Depends on mbpt_pkg.
`default_nettype none
`include "masked_bit_plane_transposer_macros.svh"
module mbpt_merge #(
	parameter int unsigned LANES = mbpt_pkg::LanesDef
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   load,
	input  wire logic     [LANES-1:0]                   load_mask,
	input  wire logic     [mbpt_pkg::IdxW-1:0]          load_idx,
	input  wire logic     [LANES-1:0][mbpt_pkg::SampleW-1:0] snap,
	input  wire logic                                   trl_push,
	input  wire mbpt_pkg::trailer_t                     trl_in,
	output logic                                        busy,
	output logic                                        out_valid,
	input  wire logic                                   out_ready,
	output mbpt_pkg::out_t                              out_data
);

	localparam int unsigned LaneIdxW = (LANES > 1) ? $clog2(LANES) : 1;

	logic [LANES-1:0]             rem_q;
	logic [mbpt_pkg::RankW-1:0]   rank_q;
	logic [mbpt_pkg::IdxW-1:0]    sidx_q;
	logic                         trl_pend_q;
	mbpt_pkg::trailer_t           trl_q;
	logic                         out_valid_q;
	mbpt_pkg::out_t               out_q;

	logic                         adv;
	logic                         drain;
	logic [LANES-1:0]             rem_clr;
	logic [LaneIdxW-1:0]          sel;
	logic                         last_w;
	mbpt_pkg::out_t               nxt;

	assign adv     = !out_valid_q || out_ready;
	assign drain   = |rem_q;
	assign rem_clr = rem_q & (rem_q - LANES'(1));
	assign last_w  = !(|rem_clr);
	assign busy    = drain || trl_pend_q;

	// lowest remaining lane
	always_comb begin
		sel = '0;
		for (int i = LANES - 1; i >= 0; i--) begin
			if (rem_q[i]) begin
				sel = LaneIdxW'(i);
			end
		end
	end

	always_comb begin
		nxt = '0;
		if (drain) begin
			nxt.kind         = mbpt_pkg::KIND_SAMPLE;
			nxt.chip_rank    = rank_q;
			nxt.sample_index = sidx_q;
			nxt.sample       = snap[sel];
			nxt.last         = last_w;
		end else begin
			nxt.kind       = mbpt_pkg::KIND_TRAILER;
			nxt.trigger_id = trl_q.trigger_id;
			nxt.module_id  = trl_q.module_id;
			nxt.timestamp  = trl_q.timestamp;
			nxt.last       = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q       <= '0;
			rank_q      <= '0;
			trl_pend_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				rem_q  <= load_mask;
				rank_q <= '0;
			end else if (adv && drain) begin
				rem_q  <= rem_clr;
				rank_q <= rank_q + mbpt_pkg::RankW'(1);
			end
			if (trl_push) begin
				trl_pend_q <= 1'b1;
			end else if (adv && !drain) begin
				trl_pend_q <= 1'b0;
			end
			if (adv) begin
				out_valid_q <= busy;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			sidx_q <= load_idx;
		end
		if (trl_push) begin
			trl_q <= trl_in;
		end
		if (adv && busy) begin
			out_q <= nxt;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	`MBPT_NEVER(a_load_while_busy, clk, arst_n, (load || trl_push) && busy)
	`MBPT_NEVER(a_two_sources, clk, arst_n, trl_pend_q && drain)
	`MBPT_ASSERT(a_drain_ends, clk, arst_n, (adv && drain && last_w && !load) |=> (rem_q == '0))

endmodule
`default_nettype wire

>>> src/masked_bit_plane_transposer.sv
// Masked bit-plane transposer: header, data and trailer control with one
// lane per mask bit and a rank-order merging stage. Depends on mbpt_pkg,
// mbpt_lane and mbpt_merge.
// A group's last data beat loads the lane snapshots and merge state, then its
// first sample the output register; a trailer result the trailer and output
// registers. One input beat per cycle, and one result per cycle while out_ready
// is high; a group-ending beat or third trailer word waits while results drain.
// Reset clears all control state and lane accumulators at once.
`default_nettype none
module masked_bit_plane_transposer #(
	parameter int unsigned SAMPLES     = mbpt_pkg::SamplesDef,
	parameter int unsigned SAMPLE_BITS = mbpt_pkg::SampleBitsDef,
	parameter int unsigned LANES       = mbpt_pkg::LanesDef
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_ready,
	input  wire mbpt_pkg::in_t  in_data,
	output logic                out_valid,
	input  wire logic           out_ready,
	output mbpt_pkg::out_t      out_data
);

	localparam logic [mbpt_pkg::StepW-1:0] TopBit  = mbpt_pkg::StepW'(SAMPLE_BITS - 1);
	localparam logic [11:0]                LastIdx = 12'(SAMPLES - 1);

	logic [LANES-1:0]                  mask_q;
	logic [mbpt_pkg::StepW-1:0]        step_q;
	logic [mbpt_pkg::IdxW-1:0]         cnt_q;
	logic                              done_q;
	logic [1:0]                        tstep_q;
	logic [31:0]                       tid_q;
	logic [31:0]                       tslo_q;

	logic                              acc;
	logic                              is_hdr;
	logic                              data_live;
	logic                              grp_end;
	logic                              trl_last;
	logic                              busy;
	mbpt_pkg::lane_ctl_t               ctl;
	mbpt_pkg::trailer_t                trl;
	logic [LANES-1:0][mbpt_pkg::SampleW-1:0] snap;

	assign is_hdr    = in_data.op == mbpt_pkg::OP_HEADER;
	assign data_live = (in_data.op == mbpt_pkg::OP_DATA) && !done_q;
	assign grp_end   = data_live && (step_q == TopBit);
	assign trl_last  = (in_data.op == mbpt_pkg::OP_TRAILER) && (tstep_q == 2'd2);
	assign in_ready  = !(busy && (grp_end || trl_last));
	assign acc       = in_valid && in_ready;

	assign ctl.clr     = acc && is_hdr;
	assign ctl.shift   = acc && data_live;
	assign ctl.grp_end = grp_end;
	assign ctl.pos     = TopBit - step_q;

	assign trl.trigger_id = tid_q[31:8];
	assign trl.module_id  = tid_q[7:0];
	assign trl.timestamp  = {in_data.word, tslo_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q  <= '0;
			step_q  <= '0;
			cnt_q   <= '0;
			done_q  <= 1'b0;
			tstep_q <= '0;
			tid_q   <= '0;
			tslo_q  <= '0;
		end else if (acc) begin
			case (in_data.op)
				mbpt_pkg::OP_HEADER: begin
					mask_q  <= in_data.word[LANES-1:0];
					step_q  <= '0;
					cnt_q   <= '0;
					done_q  <= 1'b0;
					tstep_q <= '0;
				end
				mbpt_pkg::OP_DATA: begin
					if (grp_end) begin
						step_q <= '0;
						// stop at the sample limit or when the index would wrap
						if ({1'b0, cnt_q} == LastIdx || cnt_q == '1) begin
							done_q <= 1'b1;
						end else begin
							cnt_q <= cnt_q + mbpt_pkg::IdxW'(1);
						end
					end else if (data_live) begin
						step_q <= step_q + mbpt_pkg::StepW'(1);
					end
				end
				mbpt_pkg::OP_TRAILER: begin
					case (tstep_q)
						2'd0: begin
							tid_q   <= in_data.word;
							tstep_q <= 2'd1;
						end
						2'd1: begin
							tslo_q  <= in_data.word;
							tstep_q <= 2'd2;
						end
						default: begin
							tstep_q <= '0;
						end
					endcase
				end
				default: begin
				end
			endcase
		end
	end

	for (genvar l = 0; l < LANES; l++) begin : g_lane
		mbpt_lane u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (ctl),
			.bit_in (in_data.word[l]),
			.snap   (snap[l])
		);
	end

	mbpt_merge #(
		.LANES (LANES)
	) u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (acc && grp_end),
		.load_mask (mask_q),
		.load_idx  (cnt_q),
		.snap      (snap),
		.trl_push  (acc && trl_last),
		.trl_in    (trl),
		.busy      (busy),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule
`default_nettype wire
